// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Both macros sample on clk_i; the first one also stays quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_CLK(label, prop, msg)
`endif

`endif

// ===== src/olrb_pkg.sv =====
`timescale 1ns / 1ps

package olrb_pkg;

  localparam int unsigned CntW = 7;
  localparam logic [CntW-1:0] ChunkLimitReset = 7'd64;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_DRAIN = 2'd2,
    OP_ACK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUB,
    ST_FIT,
    ST_ISSUE
  } ctrl_state_e;

  typedef struct packed {
    op_e             opcode;
    logic [7:0]      data_byte;
    logic            write_last;
    logic [31:0]     cursor_in;
    logic [CntW-1:0] max_len;
    logic            send_ok;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            byte_valid;
    logic            last;
    logic [31:0]     cursor_out;
    logic [CntW-1:0] byte_count;
    logic [31:0]     overrun_total;
    logic [31:0]     send_error_total;
    logic [31:0]     bytes_sent_total;
    logic [31:0]     datagrams_sent_total;
  } out_item_t;

  typedef struct packed {
    logic [31:0] overrun;
    logic [31:0] send_error;
    logic [31:0] bytes_sent;
    logic [31:0] datagrams;
  } totals_t;

  // One span request from the controller to the reader.
  typedef struct packed {
    logic            status;     // status-only result, no bytes
    logic [31:0]     pos;        // first ring position
    logic [CntW-1:0] cnt;        // bytes to stream
    logic [31:0]     cursor;     // cursor_out of every result
    logic [31:0]     fill_level; // staged head, bounds the written entries
    logic            filled;     // every entry written at least once
  } span_cmd_t;

endpackage

// ===== src/olrb_ram.sv =====
`timescale 1ns / 1ps

module olrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/olrb_reader.sv =====
`timescale 1ns / 1ps

module olrb_reader import olrb_pkg::*; #(
  parameter int unsigned AW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  span_cmd_t       cmd_i,
  input  totals_t         totals_i,
  output logic            rd_en_o,
  output logic [AW-1:0]   rd_addr_o,
  input  logic [7:0]      rd_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o
);

  logic [CntW-1:0] rem_q;
  logic            stat_pend_q;
  logic [AW-1:0]   addr_q;
  logic [AW-1:0]   level_q;
  logic            filled_q;
  logic [31:0]     cursor_q;
  logic [CntW-1:0] count_q;

  // RAM output register acts as the middle stage
  logic rd_v_q, rd_last_q, rd_bv_q, rd_zero_q;
  logic out_v_q;
  out_item_t out_q;

  logic cmd_fire, move, issue, have_bytes;

  assign have_bytes  = (rem_q != '0);
  assign cmd_ready_o = !have_bytes && !stat_pend_q && !rd_v_q;
  assign cmd_fire    = cmd_valid_i && cmd_ready_o;
  assign move        = rd_v_q && (!out_v_q || out_ready_i);
  assign issue       = (have_bytes || stat_pend_q) && (!rd_v_q || move);
  assign rd_en_o     = issue && have_bytes;
  assign rd_addr_o   = addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      stat_pend_q <= 1'b0;
      rd_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      if (cmd_fire) begin
        if (cmd_i.status) begin
          stat_pend_q <= 1'b1;
        end else begin
          rem_q <= cmd_i.cnt;
        end
      end else if (issue) begin
        if (have_bytes) begin
          rem_q <= rem_q - CntW'(1);
        end else begin
          stat_pend_q <= 1'b0;
        end
      end
      if (issue) begin
        rd_v_q <= 1'b1;
      end else if (move) begin
        rd_v_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      addr_q   <= cmd_i.pos[AW-1:0];
      level_q  <= cmd_i.fill_level[AW-1:0];
      filled_q <= cmd_i.filled;
      cursor_q <= cmd_i.cursor;
      count_q  <= cmd_i.cnt;
    end else if (issue && have_bytes) begin
      addr_q <= addr_q + AW'(1);
    end
    if (issue) begin
      if (have_bytes) begin
        rd_last_q <= (rem_q == CntW'(1));
        rd_bv_q   <= 1'b1;
        // never-written entries read as zero
        rd_zero_q <= !(filled_q || (addr_q < level_q));
      end else begin
        rd_last_q <= 1'b1;
        rd_bv_q   <= 1'b0;
        rd_zero_q <= 1'b1;
      end
    end
    if (move) begin
      out_q.out_byte             <= rd_zero_q ? 8'd0 : rd_data_i;
      out_q.byte_valid           <= rd_bv_q;
      out_q.last                 <= rd_last_q;
      out_q.cursor_out           <= cursor_q;
      out_q.byte_count           <= count_q;
      out_q.overrun_total        <= totals_i.overrun;
      out_q.send_error_total     <= totals_i.send_error;
      out_q.bytes_sent_total     <= totals_i.bytes_sent;
      out_q.datagrams_sent_total <= totals_i.datagrams;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/overwriting_log_ring_buffer.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_item_i  (in_item_t)
// out       output     out_valid_o / out_ready_i  out_item_o (out_item_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i (chunk_limit)
//
// Flow: a byte write goes straight into the RAM. A snapshot read or drain
// passes through accept, subtract, fit and command issue, then one RAM read
// per byte from the single read port and the RAM output register; a
// status-only result takes no RAM read. An acknowledge passes through accept and command issue.
// Reset: no clearing pass; a fill level and a filled flag make unwritten
// entries read as zero, so items are taken right after reset.
// Stalls: out_ready_i low holds the output register and the RAM read stage;
// a new item is taken once the previous span has left the RAM stage.

`include "assert_macros.svh"

module overwriting_log_ring_buffer import olrb_pkg::*; #(
  parameter int unsigned RING_SIZE = 2048,  // power of two
  parameter int unsigned MAX_CHUNK = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CntW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(RING_SIZE);
  localparam logic [31:0] RingLen = 32'(RING_SIZE);
  localparam logic [CntW-1:0] MaxChunk = CntW'(MAX_CHUNK);

  ctrl_state_e state_q, state_d;

  logic [CntW-1:0] chunk_q;
  logic [31:0]     staged_head_q, published_head_q, drain_tail_q, pending_tail_q;
  logic [CntW-1:0] pending_count_q;
  logic            outstanding_q;
  logic            filled_q;
  totals_t         totals_q;

  // per-item working registers
  logic [31:0]     pos_q, avail_q;
  logic [CntW-1:0] lim_q, cnt_q;
  logic            drain_q, ack_q;

  logic      in_fire, cmd_valid, cmd_ready, rdr_idle;
  span_cmd_t cmd;
  logic      ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  logic            fit_over;
  logic [31:0]     fit_pos, fit_avail, span_end;
  logic [CntW-1:0] fit_cnt, read_lim, drain_lim;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign rdr_idle    = cmd_ready;

  // ------------------------------------------------------------------
  // Control sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_item_i.opcode)
            OP_READ, OP_DRAIN: state_d = ST_SUB;
            OP_ACK:            state_d = ST_ISSUE;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_SUB:   state_d = ST_FIT;
      ST_FIT:   state_d = ST_ISSUE;
      ST_ISSUE: begin
        if (cmd_ready) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_valid  = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = rdr_idle;
      ST_ISSUE: cmd_valid  = 1'b1;
      default: begin
        in_ready_o = 1'b0;
        cmd_valid  = 1'b0;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Span arithmetic
  // ------------------------------------------------------------------
  assign read_lim  = (in_item_i.max_len > MaxChunk) ? MaxChunk : in_item_i.max_len;
  assign drain_lim = (chunk_q > MaxChunk) ? MaxChunk :
                     (chunk_q == '0) ? CntW'(1) : chunk_q;

  // an overtaken cursor restarts one ring behind the published head
  assign fit_over  = (avail_q > RingLen);
  assign fit_pos   = fit_over ? (published_head_q - RingLen) : pos_q;
  assign fit_avail = fit_over ? RingLen : avail_q;
  assign fit_cnt   = (fit_avail < 32'(lim_q)) ? fit_avail[CntW-1:0] : lim_q;
  assign span_end  = pos_q + 32'(cnt_q);

  assign cmd.status     = ack_q || (cnt_q == '0);
  assign cmd.pos        = pos_q;
  assign cmd.cnt        = cnt_q;
  assign cmd.cursor     = ack_q ? pos_q : span_end;
  assign cmd.fill_level = staged_head_q;
  assign cmd.filled     = filled_q;

  // ------------------------------------------------------------------
  // Ring write path
  // ------------------------------------------------------------------
  assign ram_we    = in_fire && (in_item_i.opcode == OP_WRITE);
  assign ram_waddr = staged_head_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      chunk_q          <= ChunkLimitReset;
      staged_head_q    <= '0;
      published_head_q <= '0;
      drain_tail_q     <= '0;
      pending_tail_q   <= '0;
      pending_count_q  <= '0;
      outstanding_q    <= 1'b0;
      filled_q         <= 1'b0;
      totals_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        chunk_q <= cfg_data_i;
      end
      if (ram_we) begin
        staged_head_q <= staged_head_q + 32'd1;
        if (in_item_i.write_last) begin
          published_head_q <= staged_head_q + 32'd1;
        end
        if (ram_waddr == {AW{1'b1}}) begin
          filled_q <= 1'b1;
        end
      end
      // acknowledge commits or refuses the pending chunk
      if (in_fire && (in_item_i.opcode == OP_ACK) && outstanding_q) begin
        outstanding_q <= 1'b0;
        if (in_item_i.send_ok) begin
          drain_tail_q        <= pending_tail_q;
          totals_q.bytes_sent <= totals_q.bytes_sent + 32'(pending_count_q);
          totals_q.datagrams  <= totals_q.datagrams + 32'd1;
        end else begin
          totals_q.send_error <= totals_q.send_error + 32'd1;
        end
      end
      if ((state_q == ST_FIT) && drain_q && fit_over) begin
        totals_q.overrun <= totals_q.overrun + 32'd1;
      end
      // drain result becomes the pending chunk; an empty drain drops it
      if ((state_q == ST_ISSUE) && cmd_ready && drain_q) begin
        if (cnt_q == '0) begin
          outstanding_q <= 1'b0;
        end else begin
          pending_tail_q  <= span_end;
          pending_count_q <= cnt_q;
          outstanding_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          drain_q <= (in_item_i.opcode == OP_DRAIN);
          ack_q   <= (in_item_i.opcode == OP_ACK);
          case (in_item_i.opcode)
            OP_READ: begin
              pos_q <= in_item_i.cursor_in;
              lim_q <= read_lim;
            end
            OP_DRAIN: begin
              pos_q <= drain_tail_q;
              lim_q <= drain_lim;
            end
            OP_ACK: begin
              pos_q <= (outstanding_q && in_item_i.send_ok) ? pending_tail_q : drain_tail_q;
              cnt_q <= outstanding_q ? pending_count_q : '0;
            end
            default: begin
              pos_q <= pos_q;
            end
          endcase
        end
      end
      ST_SUB: avail_q <= published_head_q - pos_q;
      ST_FIT: begin
        pos_q <= fit_pos;
        cnt_q <= fit_cnt;
      end
      default: begin
        pos_q <= pos_q;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Ring memory and read streamer
  // ------------------------------------------------------------------
  olrb_ram #(
    .WIDTH(8),
    .DEPTH(RING_SIZE)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_item_i.data_byte),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  olrb_reader #(
    .AW(AW)
  ) u_reader (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .totals_i   (totals_q),
    .rd_en_o    (ram_re),
    .rd_addr_o  (ram_raddr),
    .rd_data_i  (ram_rdata),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `ASSERT_RST(a_take_only_when_reader_idle, in_fire |-> rdr_idle,
              "item taken while reader still streaming")
  `ASSERT_RST(a_cmd_only_when_idle, cmd_valid |-> cmd_ready,
              "span command issued while reader busy")
  `ASSERT_RST(a_pending_count_range,
              outstanding_q |-> ((pending_count_q != '0) && (pending_count_q <= MaxChunk)),
              "pending chunk size out of range")
  `ASSERT_RST(a_publish_follows_last,
              (ram_we && in_item_i.write_last) |=> (published_head_q == staged_head_q),
              "head not published after last byte")

endmodule
